// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, suspended while rst_n is low.
`define SPQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge of clk, reset included.
`define SPQ_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/spq_pkg.sv =====
`default_nettype none

package spq_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 16;

    localparam int PRI_W = 8;
    localparam int TAG_W = 16;
    localparam int OCC_W = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_PEEK   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Operation broadcast to every cell of the chain at once.
    typedef struct packed {
        logic do_insert;
        logic do_pop;
    } spq_op_t;

endpackage

`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
`default_nettype none

module spq_cell (
    input  wire logic                       clk,
    input  wire spq_pkg::spq_op_t           op,
    input  wire logic                       occupied,
    input  wire logic                       is_tail,
    input  wire logic [spq_pkg::PRI_W-1:0]  new_pri,
    input  wire logic [spq_pkg::TAG_W-1:0]  new_tag,
    input  wire logic                       left_gt,
    input  wire logic [spq_pkg::PRI_W-1:0]  left_pri,
    input  wire logic [spq_pkg::TAG_W-1:0]  left_tag,
    input  wire logic [spq_pkg::PRI_W-1:0]  right_pri,
    input  wire logic [spq_pkg::TAG_W-1:0]  right_tag,
    output logic                            gt,
    output logic [spq_pkg::PRI_W-1:0]       pri,
    output logic [spq_pkg::TAG_W-1:0]       tag
);
    import spq_pkg::*;

    logic [PRI_W-1:0] pri_reg;
    logic [PRI_W-1:0] pri_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;

    // Strictly greater keeps equal priorities in arrival order.
    assign gt  = occupied && (pri_reg > new_pri);
    assign pri = pri_reg;
    assign tag = tag_reg;

    always_comb
    begin
        pri_next = pri_reg;
        tag_next = tag_reg;
        if (op.do_insert)
        begin
            // Cells past the insertion point move up by one; the first
            // greater cell, or the first free one, takes the new entry.
            if (left_gt)
            begin
                pri_next = left_pri;
                tag_next = left_tag;
            end
            else if (gt || is_tail)
            begin
                pri_next = new_pri;
                tag_next = new_tag;
            end
        end
        else if (op.do_pop)
        begin
            pri_next = right_pri;
            tag_next = right_tag;
        end
    end

    always_ff @(posedge clk)
    begin
        pri_reg <= pri_next;
        tag_reg <= tag_next;
    end

endmodule

`default_nettype wire

// ===== rtl/core/stable_priority_queue_top.sv =====
// Channel | Handshake          | Fields
// --------+--------------------+-------------------------------------------
// request | in_valid, in_stall | cmd, new_priority, new_tag
// result  | out_valid, out_stall | status, out_tag, out_priority, occupancy
//
// One request is taken per cycle while in_stall is low; its result reaches
// the output register in the next cycle. All cells compare and shift at once.
// Reset clears the entry count and the result valid; the cells hold no reset.
// A stalled result holds in_stall high, so no request is lost while it waits.
`default_nettype none

module stable_priority_queue_top #(
    parameter int QUEUE_DEPTH = spq_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [1:0]                 cmd,
    input  wire logic [spq_pkg::PRI_W-1:0]  new_priority,
    input  wire logic [spq_pkg::TAG_W-1:0]  new_tag,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      status,
    output logic [spq_pkg::TAG_W-1:0]       out_tag,
    output logic [spq_pkg::PRI_W-1:0]       out_priority,
    output logic [spq_pkg::OCC_W-1:0]       occupancy
);
    import spq_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          status_reg;
    status_t          status_next;
    logic [TAG_W-1:0] tag_reg;
    logic [TAG_W-1:0] tag_next;
    logic [PRI_W-1:0] pri_reg;
    logic [PRI_W-1:0] pri_next;
    logic [CW-1:0]    occ_reg;

    logic    accept;
    logic    full;
    logic    empty;
    spq_op_t op;

    logic [PRI_W-1:0] cell_pri [QUEUE_DEPTH];
    logic [TAG_W-1:0] cell_tag [QUEUE_DEPTH];
    logic             cell_gt  [QUEUE_DEPTH];

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign full     = (count_reg == CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign op.do_insert = accept && (cmd == CMD_INSERT) && !full;
    assign op.do_pop    = accept && (cmd == CMD_POP) && !empty;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic             l_gt;
        logic [PRI_W-1:0] l_pri;
        logic [TAG_W-1:0] l_tag;
        logic [PRI_W-1:0] r_pri;
        logic [TAG_W-1:0] r_tag;

        if (i == 0)
        begin : g_head
            assign l_gt  = 1'b0;
            assign l_pri = new_priority;
            assign l_tag = new_tag;
        end
        else
        begin : g_body
            assign l_gt  = cell_gt[i-1];
            assign l_pri = cell_pri[i-1];
            assign l_tag = cell_tag[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign r_pri = cell_pri[i];
            assign r_tag = cell_tag[i];
        end
        else
        begin : g_next
            assign r_pri = cell_pri[i+1];
            assign r_tag = cell_tag[i+1];
        end

        spq_cell u_cell (
            .clk       (clk),
            .op        (op),
            .occupied  (CW'(i) < count_reg),
            .is_tail   (CW'(i) == count_reg),
            .new_pri   (new_priority),
            .new_tag   (new_tag),
            .left_gt   (l_gt),
            .left_pri  (l_pri),
            .left_tag  (l_tag),
            .right_pri (r_pri),
            .right_tag (r_tag),
            .gt        (cell_gt[i]),
            .pri       (cell_pri[i]),
            .tag       (cell_tag[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.do_insert)
            count_next = count_reg + CW'(1);
        else if (op.do_pop)
            count_next = count_reg - CW'(1);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;

        status_next = ST_OK;
        tag_next    = '0;
        pri_next    = '0;
        case (cmd)
            CMD_INSERT:
            begin
                if (full)
                    status_next = ST_FULL;
            end
            CMD_POP, CMD_PEEK:
            begin
                if (empty)
                    status_next = ST_EMPTY;
                else
                begin
                    tag_next = cell_tag[0];
                    pri_next = cell_pri[0];
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            tag_reg    <= tag_next;
            pri_reg    <= pri_next;
            occ_reg    <= count_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign out_tag      = tag_reg;
    assign out_priority = pri_reg;
    assign occupancy    = OCC_W'(occ_reg);

    `SPQ_ASSERT(a_count_bound, count_reg <= CW'(QUEUE_DEPTH),
        "entry count beyond depth")
    `SPQ_ASSERT(a_insert_count, op.do_insert |=> count_reg == $past(count_reg) + CW'(1),
        "insert did not grow count")
    `SPQ_ASSERT(a_pop_head,
        op.do_pop |=> out_priority == $past(cell_pri[0]) && out_tag == $past(cell_tag[0]),
        "pop returned wrong head")
    `SPQ_ASSERT(a_full_occ, out_valid && status == ST_FULL |-> occ_reg == CW'(QUEUE_DEPTH),
        "full status with free slots")

endmodule

`default_nettype wire

// ===== tb/sv/tb_stable_priority_queue_top.sv =====
`timescale 1ns / 1ps

module tb_stable_priority_queue_top;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT;
    // The command code that the block leaves unused; it must do nothing.
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        status_t            status;
        logic [TAG_W-1:0]   tag;
        logic [PRI_W-1:0]   pri;
        logic [OCC_W-1:0]   occ;
    } response_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         cmd = CMD_INSERT;
    logic [PRI_W-1:0]   new_priority = '0;
    logic [TAG_W-1:0]   new_tag = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status;
    logic [TAG_W-1:0]   out_tag;
    logic [PRI_W-1:0]   out_priority;
    logic [OCC_W-1:0]   occupancy;

    // Shadow copy of the sorted queue, slot 0 holding the lowest entry.
    logic [PRI_W-1:0]   held_priority [QUEUE_DEPTH];
    logic [TAG_W-1:0]   held_tag [QUEUE_DEPTH];
    int                 held_count = 0;

    response_t          expected_responses [$];
    response_t          oldest_response;
    int                 requests_sent = 0;
    int                 mismatch_count = 0;
    int                 idle_cycles = 0;
    bit                 idling_on = 1'b1;
    bit                 long_hold_pending = 1'b0;

    stable_priority_queue_top #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .new_priority (new_priority),
        .new_tag      (new_tag),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .out_tag      (out_tag),
        .out_priority (out_priority),
        .occupancy    (occupancy)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic response_t predict_response(logic [1:0] c, logic [PRI_W-1:0] p,
                                                   logic [TAG_W-1:0] t);
        response_t r;
        int pos;
        r = '{status: ST_OK, tag: '0, pri: '0, occ: '0};
        if (c == CMD_INSERT)
        begin
            if (held_count >= QUEUE_DEPTH)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                // New entry goes behind every entry of equal or lower priority.
                pos = 0;
                while (pos < held_count && held_priority[pos] <= p)
                    pos++;
                for (int k = held_count; k > pos; k--)
                begin
                    held_priority[k] = held_priority[k-1];
                    held_tag[k] = held_tag[k-1];
                end
                held_priority[pos] = p;
                held_tag[pos] = t;
                held_count++;
            end
        end
        else if (c == CMD_POP || c == CMD_PEEK)
        begin
            if (held_count == 0)
            begin
                r.status = ST_EMPTY;
            end
            else
            begin
                r.tag = held_tag[0];
                r.pri = held_priority[0];
                if (c == CMD_POP)
                begin
                    for (int k = 0; k + 1 < held_count; k++)
                    begin
                        held_priority[k] = held_priority[k+1];
                        held_tag[k] = held_tag[k+1];
                    end
                    held_count--;
                end
            end
        end
        r.occ = OCC_W'(held_count);
        return r;
    endfunction

    function automatic logic [PRI_W-1:0] random_priority(bit narrow);
        return narrow ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [1:0] random_command();
        int draw;
        draw = $urandom_range(0, 15);
        if (draw < 7)
            return CMD_INSERT;
        else if (draw < 12)
            return CMD_POP;
        else if (draw < 15)
            return CMD_PEEK;
        else
            return CMD_NONE;
    endfunction

    task automatic send_request(logic [1:0] c, logic [PRI_W-1:0] p, logic [TAG_W-1:0] t);
        int gap;
        gap = idling_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        new_priority <= p;
        new_tag <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_responses.push_back(predict_response(c, p, t));
        requests_sent++;
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(string field, int expected_value, int actual_value);
        $display("%0t: %s expected %0d, got %0d", $time, field, expected_value,
                 actual_value);
        mismatch_count++;
    endtask

    task automatic test_empty_commands();
        send_request(CMD_POP, 8'hFF, 16'hFFFF);
        send_request(CMD_PEEK, 8'h00, 16'h0000);
        send_request(CMD_NONE, 8'hA5, 16'h5A5A);
    endtask

    // Fill to the brim with extremes and repeated priorities, so that the
    // order among equal priorities shows up when the queue is drained.
    task automatic test_fill_with_ties();
        logic [PRI_W-1:0] pri_list [16] = '{8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd7,
                                            8'd7, 8'd7, 8'd1, 8'd254, 8'd128, 8'd0,
                                            8'd255, 8'd64, 8'd7, 8'd1};
        for (int k = 0; k < QUEUE_DEPTH; k++)
            send_request(CMD_INSERT, pri_list[k % 16], TAG_W'(k * 16'h1111));
    endtask

    task automatic test_full_queue();
        send_request(CMD_INSERT, 8'h00, 16'hABCD);
        send_request(CMD_NONE, 8'hFF, 16'hFFFF);
        send_request(CMD_PEEK, 8'h00, 16'h0000);
        send_request(CMD_POP, 8'h00, 16'h0000);
    endtask

    // Bursts of inserts followed by bursts of pops, so the queue swings
    // between empty and full with random contents.
    task automatic test_fill_drain_bursts(int request_target);
        int burst;
        bit narrow;
        while (requests_sent < request_target)
        begin
            idling_on = ($urandom_range(0, 3) != 0);
            narrow = $urandom_range(0, 1);
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(CMD_PEEK, random_priority(0), TAG_W'($urandom));
                else
                    send_request(CMD_INSERT, random_priority(narrow), TAG_W'($urandom));
            end
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                if ($urandom_range(0, 7) == 0)
                    send_request(CMD_PEEK, random_priority(0), TAG_W'($urandom));
                else
                    send_request(CMD_POP, random_priority(0), TAG_W'($urandom));
            end
        end
        idling_on = 1'b1;
    endtask

    task automatic test_random_mix(int request_target);
        while (requests_sent < request_target)
            send_request(random_command(), random_priority($urandom_range(0, 1)),
                         TAG_W'($urandom));
    endtask

    // The result side holds off for a long stretch while requests keep coming.
    task automatic test_result_hold();
        long_hold_pending = 1'b1;
        idling_on = 1'b0;
        repeat (40)
            send_request(random_command(), random_priority(1), TAG_W'($urandom));
        wait_for_drain();
        idling_on = 1'b1;
    endtask

    task automatic test_drain_pauses(int request_target);
        while (requests_sent < request_target)
        begin
            repeat (15)
                send_request(random_command(), random_priority($urandom_range(0, 1)),
                             TAG_W'($urandom));
            wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_commands();
        test_fill_with_ties();
        test_full_queue();
        test_fill_drain_bursts(900);
        test_random_mix(1200);
        test_result_hold();
        test_drain_pauses(1450);
        wait_for_drain();
        repeat (5) @(posedge clk);
        if (mismatch_count == 0)
            $display("stable_priority_queue_top test passed");
        else
            $display("stable_priority_queue_top test failed");
        $finish;
    end

    // Result side: a random hold-off before each result, or a long one on request.
    initial
    begin
        int hold_cycles;
        wait (rst_n);
        forever
        begin
            if (long_hold_pending)
            begin
                hold_cycles = LONG_HOLD_CYCLES;
                long_hold_pending = 1'b0;
            end
            else
            begin
                hold_cycles = idling_on ? $urandom_range(0, 5) : 0;
            end
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_cycles) @(posedge clk);
                out_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_responses.size() == 0)
            begin
                $display("%0t: result with no request outstanding, status %0d tag %0d",
                         $time, status, out_tag);
                mismatch_count++;
            end
            else
            begin
                oldest_response = expected_responses.pop_front();
                if (status !== oldest_response.status)
                    report_mismatch("status", oldest_response.status, status);
                if (out_tag !== oldest_response.tag)
                    report_mismatch("out_tag", oldest_response.tag, out_tag);
                if (out_priority !== oldest_response.pri)
                    report_mismatch("out_priority", oldest_response.pri, out_priority);
                if (occupancy !== oldest_response.occ)
                    report_mismatch("occupancy", oldest_response.occ, occupancy);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("stable_priority_queue_top test failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/stable_priority_queue_top.sv
tb/sv/tb_stable_priority_queue_top.sv
